/* rtl/dltq_pkg.sv */
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and constants of the delta-list timer queue
// Slot count, pointer widths and the in/out transfer structs.
// ----------------------------------------------------------------------------
package dltq_pkg;

	localparam int Capacity = 32;
	localparam int SlotW    = $clog2(Capacity);
	localparam int PtrW     = $clog2(Capacity + 1);
	localparam int CountW   = $clog2(Capacity + 1);
	localparam logic [PtrW-1:0] Nil = PtrW'(Capacity);

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	localparam logic EV_EXPIRED = 1'b0;
	localparam logic EV_REJECT  = 1'b1;

	typedef struct packed {
		logic [1:0]  action;
		logic [30:0] time_ms;
		logic [31:0] tag;
		logic [15:0] reply_port;
	} in_item_t;

	typedef struct packed {
		logic        event_kind;
		logic [31:0] expired_tag;
		logic [15:0] expired_port;
		logic        last;
	} out_item_t;

endpackage

/* rtl/delta_list_timer_queue.sv */
// ----------------------------------------------------------------------------
// delta_list_timer_queue: timer queue kept as a linked delta list
// Slots live in one synchronous memory; a sequencer walks the list, one
// slot read per step, and writes entries back.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  in_item  | in  | in_valid/in_stall  | in_item_t
//  out_item | out | out_valid/out_stall| out_item_t
//
// One item at a time: accept, dispatch, then a memory read and a compare
// and update for each slot walked. Insert and cancel close after the walk.
// A tick adds a head read and an evaluation per expiry, then closes.
// Reset clears the head pointer, slot map and count; the slot memory is
// not cleared. A stalled result holds the sequencer until the result
// register frees.
module delta_list_timer_queue import dltq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	typedef struct packed {
		logic [30:0]     delta;
		logic [31:0]     tag;
		logic [15:0]     port;
		logic [PtrW-1:0] nxt;
	} slot_t;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b0_0000_0001,
		S_DISP  = 9'b0_0000_0010,
		S_RD    = 9'b0_0000_0100,
		S_EVAL  = 9'b0_0000_1000,
		S_FIX   = 9'b0_0001_0000,
		S_HRD   = 9'b0_0010_0000,
		S_HEVAL = 9'b0_0100_0000,
		S_OUT   = 9'b0_1000_0000,
		S_LINK  = 9'b1_0000_0000
	} state_t;

	slot_t mem [Capacity];
	slot_t rd_q;
	logic             we;
	logic [SlotW-1:0] waddr, raddr;
	slot_t            wdata;

	state_t state_q;
	in_item_t req_q;
	logic [30:0] t_q;
	logic [PtrW-1:0] head_q, cur_q, prev_q, cnxt_q;
	logic [Capacity-1:0] used_q;
	logic [CountW-1:0] count_q;
	logic [SlotW-1:0] free_q;
	logic [30:0] cdelta_q;
	logic ticked_q;
	out_item_t out_q;
	logic out_valid_q;
	slot_t prev_slot_q;
	// one expiry is held back so the final one can carry last
	out_item_t pend_q;

	logic      out_free;
	logic      out_load;
	out_item_t out_next;
	logic      reject_c;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// lowest free slot
	logic [SlotW-1:0] free_c;
	always_comb begin
		free_c = '0;
		for (int i = Capacity - 1; i >= 0; i--)
			if (!used_q[i]) free_c = SlotW'(i);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign reject_c  = (req_q.action == ACT_INSERT) && (count_q >= CountW'(Capacity));

	always_comb begin
		raddr = cur_q[SlotW-1:0];
		if (state_q == S_FIX && req_q.action == ACT_CANCEL) raddr = cnxt_q[SlotW-1:0];
		else if (state_q == S_HRD || state_q == S_HEVAL) raddr = head_q[SlotW-1:0];
	end

	always_comb begin
		we = 1'b0; waddr = cur_q[SlotW-1:0]; wdata = rd_q;
		unique case (state_q)
			S_EVAL: begin
				unique case (req_q.action)
					ACT_INSERT: begin
						if (cur_q != Nil && !(t_q > rd_q.delta)) begin
							we = 1'b1; wdata.delta = rd_q.delta - t_q;
						end
					end
					ACT_TICK: begin
						if (cur_q != Nil && t_q != '0) begin
							we = 1'b1;
							wdata.delta = (t_q > rd_q.delta) ? '0 : rd_q.delta - t_q;
						end
					end
					default: ;
				endcase
			end
			S_FIX: begin
				// insert: write new slot; cancel: relink predecessor
				if (req_q.action == ACT_INSERT) begin
					we = 1'b1; waddr = free_q;
					wdata.delta = t_q; wdata.tag = req_q.tag;
					wdata.port = req_q.reply_port; wdata.nxt = cur_q;
				end else if (prev_q != Nil) begin
					we = 1'b1; waddr = prev_q[SlotW-1:0];
					wdata = prev_slot_q; wdata.nxt = cnxt_q;
				end
			end
			S_LINK: begin
				// insert behind a predecessor: point it at the new slot
				we = 1'b1; waddr = prev_q[SlotW-1:0];
				wdata = prev_slot_q; wdata.nxt = PtrW'(free_q);
			end
			S_HEVAL: begin
				// cancel second half: add removed delta to follower
				if (req_q.action == ACT_CANCEL) begin
					we = 1'b1; waddr = cnxt_q[SlotW-1:0];
					wdata.delta = rd_q.delta + cdelta_q;
				end
			end
			default: ;
		endcase
	end

	// result register load: reject, or the held expiry once its successor is known
	always_comb begin
		out_load = 1'b0;
		out_next = pend_q;
		if (state_q == S_DISP && reject_c) begin
			out_load = 1'b1;
			out_next = '{EV_REJECT, req_q.tag, req_q.reply_port, 1'b1};
		end else if (state_q == S_HRD && head_q == Nil && ticked_q && out_free) begin
			out_load = 1'b1;
			out_next.last = 1'b1;
		end else if (state_q == S_HEVAL && req_q.action == ACT_TICK && ticked_q && out_free) begin
			out_load = 1'b1;
			out_next.last = (rd_q.delta != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= out_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= Nil;
			used_q <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_item;
						t_q <= in_item.time_ms;
						cur_q <= head_q;
						prev_q <= Nil;
						ticked_q <= 1'b0;
						free_q <= free_c;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					priority if (reject_c) begin
						state_q <= S_OUT;
					end else if (req_q.action == ACT_NONE) begin
						state_q <= S_IDLE;
					end else if (cur_q == Nil) begin
						priority if (req_q.action == ACT_INSERT) state_q <= S_FIX;
						else if (req_q.action == ACT_TICK) state_q <= S_HRD;
						else state_q <= S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_EVAL;
				S_EVAL: begin
					unique case (req_q.action)
						ACT_INSERT: begin
							if (t_q > rd_q.delta) begin
								t_q <= t_q - rd_q.delta;
								prev_q <= cur_q; prev_slot_q <= rd_q;
								cur_q <= rd_q.nxt;
								state_q <= (rd_q.nxt == Nil) ? S_FIX : S_RD;
							end else begin
								state_q <= S_FIX;
							end
						end
						ACT_CANCEL: begin
							if (rd_q.tag == req_q.tag) begin
								cnxt_q <= rd_q.nxt;
								cdelta_q <= rd_q.delta;
								if (prev_q == Nil) head_q <= rd_q.nxt;
								used_q[cur_q[SlotW-1:0]] <= 1'b0;
								count_q <= count_q - CountW'(1);
								state_q <= S_FIX;
							end else begin
								prev_q <= cur_q; prev_slot_q <= rd_q;
								cur_q <= rd_q.nxt;
								state_q <= (rd_q.nxt == Nil) ? S_IDLE : S_RD;
							end
						end
						default: begin // tick
							if (t_q > rd_q.delta) begin
								t_q <= t_q - rd_q.delta;
								cur_q <= rd_q.nxt;
								state_q <= (rd_q.nxt == Nil) ? S_HRD : S_RD;
							end else begin
								t_q <= '0;
								state_q <= S_HRD;
							end
						end
					endcase
				end
				S_FIX: begin
					if (req_q.action == ACT_INSERT) begin
						if (prev_q == Nil) head_q <= PtrW'(free_q);
						used_q[free_q] <= 1'b1;
						count_q <= count_q + CountW'(1);
						state_q <= (prev_q == Nil) ? S_IDLE : S_LINK;
					end else begin
						state_q <= (cnxt_q == Nil) ? S_IDLE : S_HEVAL;
					end
				end
				S_LINK: state_q <= S_IDLE;
				S_HRD: begin
					// head read for expiry
					if (head_q != Nil) state_q <= S_HEVAL;
					else if (!ticked_q) state_q <= S_IDLE;
					else if (out_free) state_q <= S_OUT;
				end
				S_HEVAL: begin
					if (req_q.action == ACT_CANCEL) begin
						state_q <= S_IDLE;
					end else if (rd_q.delta == '0) begin
						// previous expiry must leave before this one is held
						if (!ticked_q || out_free) begin
							pend_q <= '{EV_EXPIRED, rd_q.tag, rd_q.port, 1'b0};
							ticked_q <= 1'b1;
							used_q[head_q[SlotW-1:0]] <= 1'b0;
							count_q <= count_q - CountW'(1);
							head_q <= rd_q.nxt;
							state_q <= S_HRD;
						end
					end else if (!ticked_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						state_q <= S_OUT;
					end
				end
				default: begin // S_OUT
					if (!out_stall) state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
